// ===== sv/amq_pkg.sv =====
package amq_pkg;

	localparam int VALUE_BITS = 24;
	localparam int QUOT_BITS = 7;
	localparam int CODE_BITS = 8;
	localparam int NUM_BITS = VALUE_BITS + QUOT_BITS;
	localparam int CNT_BITS = $clog2(QUOT_BITS);
	localparam int USER_IN_BITS = 2;
	localparam int IN_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((CODE_BITS + VALUE_BITS + 7) / 8) * 8;

	localparam logic [QUOT_BITS-1:0] CODE_LIMIT = {QUOT_BITS{1'b1}};

	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_QUANT = 1'b1;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_ROUND,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic start;
		logic ack;
		logic neg;
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] maxv;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [CODE_BITS-1:0] code;
	} div_rsp_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic [VALUE_BITS-1:0] mag;
	} max_upd_t;

	function automatic logic [VALUE_BITS-1:0] amq_magnitude(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] m;
		m = v[VALUE_BITS-1] ? (VALUE_BITS'(0) - v) : v;
		return m;
	endfunction

endpackage

// ===== sv/amq_max_track.sv =====
module amq_max_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  amq_pkg::max_upd_t             upd,
	output logic [amq_pkg::VALUE_BITS-1:0] maxv
);
	import amq_pkg::*;

	logic [VALUE_BITS-1:0] running_max_q;
	logic [VALUE_BITS-1:0] base;

	assign base = upd.clr ? '0 : running_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_max_q <= '0;
		end else if (upd.en) begin
			running_max_q <= (upd.mag > base) ? upd.mag : base;
		end
	end

	assign maxv = running_max_q;

endmodule

// ===== sv/amq_divider.sv =====
module amq_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  amq_pkg::div_req_t req,
	output amq_pkg::div_rsp_t rsp
);
	import amq_pkg::*;

	div_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] rem_q;
	logic [QUOT_BITS-1:0]  numlo_q;
	logic [QUOT_BITS-1:0]  quot_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  neg_q;
	logic [CODE_BITS-1:0]  code_q;

	logic [NUM_BITS-1:0]   num;
	logic [VALUE_BITS:0]   maxv_ext;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  ge;
	logic [VALUE_BITS:0]   twice;
	logic                  round_up;
	logic [QUOT_BITS:0]    qr;
	logic [QUOT_BITS-1:0]  qc;
	logic [CODE_BITS-1:0]  round_code;
	logic [CODE_BITS-1:0]  sat_code;
	logic                  is_zero;
	logic                  is_over;
	logic                  last_step;

	// 127 * mag is formed as (mag << 7) - mag.
	assign num = (NUM_BITS'(req.mag) << QUOT_BITS) - NUM_BITS'(req.mag);
	assign maxv_ext = {1'b0, req.maxv};
	assign is_zero = (req.maxv == '0);
	assign is_over = (req.mag > req.maxv);
	assign sat_code = is_zero ? '0 :
		(req.neg ? (CODE_BITS'(0) - CODE_BITS'(CODE_LIMIT)) : CODE_BITS'(CODE_LIMIT));

	// One restoring step per cycle; the remainder always stays below the maximum.
	assign trial = {rem_q, numlo_q[QUOT_BITS-1]};
	assign ge = (trial >= maxv_ext);
	assign diff = trial - maxv_ext;
	assign last_step = (cnt_q == CNT_BITS'(QUOT_BITS - 1));

	// Round half to even, then clamp to the code limit.
	assign twice = {rem_q, 1'b0};
	assign round_up = (twice > maxv_ext) || ((twice == maxv_ext) && quot_q[0]);
	assign qr = {1'b0, quot_q} + (QUOT_BITS + 1)'(round_up);
	assign qc = qr[QUOT_BITS] ? CODE_LIMIT : qr[QUOT_BITS-1:0];
	assign round_code = neg_q ? (CODE_BITS'(0) - CODE_BITS'(qc)) : CODE_BITS'(qc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rsp.busy = 1'b1;
		rsp.done = 1'b0;
		rsp.code = code_q;
		case (state_q)
			DIV_IDLE: begin
				rsp.busy = 1'b0;
				if (req.start) begin
					state_d = (is_zero || is_over) ? DIV_DONE : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (last_step) begin
					state_d = DIV_ROUND;
				end
			end
			DIV_ROUND: begin
				state_d = DIV_DONE;
			end
			DIV_DONE: begin
				rsp.done = 1'b1;
				if (req.ack) begin
					state_d = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (req.start) begin
					rem_q <= num[NUM_BITS-1 -: VALUE_BITS];
					numlo_q <= num[QUOT_BITS-1:0];
					quot_q <= '0;
					cnt_q <= '0;
					neg_q <= req.neg;
					code_q <= sat_code;
				end
			end
			DIV_RUN: begin
				rem_q <= ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
				quot_q <= {quot_q[QUOT_BITS-2:0], ge};
				numlo_q <= {numlo_q[QUOT_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			DIV_ROUND: begin
				code_q <= round_code;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/absmax_int8_quantizer.sv =====
// Channel  Dir  tdata                          tuser              tlast
// s_axis   in   value                          action, first      last
// m_axis   out  code, max_magnitude            -                  end_of_pass
//
// A scan transfer updates the running maximum at its edge.
// A quantize transfer loads the divider, runs the bit-serial divider, rounds,
// and hands the code to the output register.
// A zero maximum or an element above the maximum skips the divider.
// Reset clears the running maximum and all valid state.
// The output register lets the next item enter while a code waits for m_axis_tready.
module absmax_int8_quantizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [amq_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // value
	input  logic [amq_pkg::USER_IN_BITS-1:0]   s_axis_tuser,  // action, first
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [amq_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // code, max_magnitude
	output logic                               m_axis_tlast
);
	import amq_pkg::*;

	logic                     in_xfer;
	logic                     quant_xfer;
	logic [VALUE_BITS-1:0]    in_value;
	logic [VALUE_BITS-1:0]    in_mag;
	logic [VALUE_BITS-1:0]    maxv;
	logic                     ack;
	logic                     last_q;
	logic                     m_valid_q;
	logic [OUT_DATA_BITS-1:0] m_data_q;
	logic                     m_last_q;
	max_upd_t                 upd;
	div_req_t                 req;
	div_rsp_t                 rsp;

	assign in_value = s_axis_tdata[VALUE_BITS-1:0];
	assign in_mag = amq_magnitude(in_value);
	assign s_axis_tready = !rsp.busy;
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign quant_xfer = in_xfer && (s_axis_tuser[0] == ACT_QUANT);

	assign upd.en = in_xfer && (s_axis_tuser[0] == ACT_SCAN);
	assign upd.clr = s_axis_tuser[1];
	assign upd.mag = in_mag;

	amq_max_track u_max (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.maxv   (maxv)
	);

	assign ack = rsp.done && (!m_valid_q || m_axis_tready);
	assign req.start = quant_xfer;
	assign req.ack = ack;
	assign req.neg = in_value[VALUE_BITS-1];
	assign req.mag = in_mag;
	assign req.maxv = maxv;

	amq_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ack) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (quant_xfer) begin
			last_q <= s_axis_tlast;
		end
		if (ack) begin
			m_data_q <= OUT_DATA_BITS'({maxv, rsp.code});
			m_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tlast = m_last_q;

	a_quant_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		quant_xfer |=> !s_axis_tready)
		else $error("input still ready after a quantize transfer");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[CODE_BITS-1:0] != {1'b1, {(CODE_BITS-1){1'b0}}}))
		else $error("code outside the symmetric range");

	a_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[CODE_BITS +: VALUE_BITS] == '0))
		|-> (m_axis_tdata[CODE_BITS-1:0] == '0))
		else $error("nonzero code with a zero maximum");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		ack |=> (m_axis_tvalid && !rsp.done))
		else $error("divider result not moved to the output register");

endmodule
